>>> src/chic_pkg.sv
// Shared constants, types and the arctangent table for the compass heading block.
package chic_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int DW = SAMPLE_BITS + 18;
   localparam int FULL_CENTIDEG = 36000;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_END = 2'd2;

   typedef struct packed {
      logic                 is_sample;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic                 flag;
      logic signed [16:0]   ox;
      logic signed [16:0]   oy;
   } entry_type;

   function automatic logic [31:0] atan_bam(input logic [CNT_W-1:0] i);
      logic [31:0] r;
      case (32'(i))
         0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
         3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
         6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
         9: r = 32'h00145F2E;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
         12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
         15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
         18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
         21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
         default: r = 32'h00000028;
      endcase
      return r;
   endfunction

endpackage

>>> src/chic_if.sv
// Request and response channel interfaces.
interface cal_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [15:0] mag_x;
   logic signed [15:0] mag_y;
   modport source (output valid, cmd, mag_x, mag_y, input ready);
   modport sink (input valid, cmd, mag_x, mag_y, output ready);
endinterface

interface cal_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        heading_centideg;
   logic               calibrating_flag;
   logic signed [16:0] offset_x_doubled;
   logic signed [16:0] offset_y_doubled;
   modport source (output valid, heading_centideg, calibrating_flag, offset_x_doubled,
                   offset_y_doubled, input ready);
   modport sink (input valid, heading_centideg, calibrating_flag, offset_x_doubled,
                 offset_y_doubled, output ready);
endinterface

>>> src/chic_front.sv
// Front end: accepts transactions, tracks calibration and forms the offset-corrected vector.
module chic_front (
   input  logic              clock,
   input  logic              reset,
   cal_req_if.sink           req,
   input  logic              q_full,
   output logic              q_push,
   output chic_pkg::entry_type q_data
);
   import chic_pkg::*;

   logic signed [15:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic signed [15:0] xmin_in, xmax_in, ymin_in, ymax_in;
   logic signed [16:0] ox_ff, oy_ff, ox_in, oy_in;
   logic               trk_ff, trk_in;
   logic signed [15:0] sx, sy;
   logic signed [17:0] ddx, ddy;

   assign req.ready = !q_full;
   assign q_push = req.valid && !q_full;

   assign sx = 16'(signed'(req.mag_x[SAMPLE_BITS-1:0]));
   assign sy = 16'(signed'(req.mag_y[SAMPLE_BITS-1:0]));
   assign ddx = 18'(sx) * 18'sd2 - 18'(ox_ff);
   assign ddy = 18'(sy) * 18'sd2 - 18'(oy_ff);

   always_comb begin
      xmin_in = xmin_ff; xmax_in = xmax_ff; ymin_in = ymin_ff; ymax_in = ymax_ff;
      ox_in = ox_ff; oy_in = oy_ff; trk_in = trk_ff;
      case (req.cmd)
         CMD_SAMPLE: begin
            if (trk_ff) begin
               if (sx < xmin_ff) xmin_in = sx;
               if (sx > xmax_ff) xmax_in = sx;
               if (sy < ymin_ff) ymin_in = sy;
               if (sy > ymax_ff) ymax_in = sy;
            end
         end
         CMD_START: begin
            trk_in = 1'b1;
            xmin_in = 16'sd32767; xmax_in = -16'sd32768;
            ymin_in = 16'sd32767; ymax_in = -16'sd32768;
         end
         CMD_END: begin
            trk_in = 1'b0;
            ox_in = 17'(xmin_ff) + 17'(xmax_ff);
            oy_in = 17'(ymin_ff) + 17'(ymax_ff);
         end
         default: ;
      endcase
      q_data.is_sample = (req.cmd == CMD_SAMPLE);
      q_data.dx = DW'(ddx) <<< 12;
      q_data.dy = DW'(ddy) <<< 12;
      q_data.flag = trk_in;
      q_data.ox = ox_in;
      q_data.oy = oy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xmin_ff <= 16'sd32767; xmax_ff <= -16'sd32768;
         ymin_ff <= 16'sd32767; ymax_ff <= -16'sd32768;
         ox_ff <= '0; oy_ff <= '0; trk_ff <= 1'b0;
      end else if (q_push) begin
         xmin_ff <= xmin_in; xmax_ff <= xmax_in; ymin_ff <= ymin_in; ymax_ff <= ymax_in;
         ox_ff <= ox_in; oy_ff <= oy_in; trk_ff <= trk_in;
      end
   end
endmodule

>>> src/chic_queue.sv
// Two-entry queue between front end and back end.
module chic_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  chic_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output chic_pkg::entry_type pop_data
);
   import chic_pkg::*;

   entry_type  mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> src/chic_back.sv
// Back end: iterative CORDIC, declination and folding, response register.
module chic_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic signed [15:0]  csr_wdata,
   input  logic                q_valid,
   input  chic_pkg::entry_type q_data,
   output logic                q_pop,
   cal_rsp_if.source           rsp
);
   import chic_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_RUN   = 5'b00010,
      S_SCALE = 5'b00100,
      S_FOLD  = 5'b01000,
      S_WAIT  = 5'b10000
   } state_type;

   state_type          st_ff;
   logic signed [DW-1:0] x_ff, y_ff, xs, ys;
   logic [31:0]        z_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic signed [47:0] prod_ff;
   logic signed [47:0] rnd;
   logic signed [18:0] ang, h0, h;
   logic [15:0]        head_ff;
   logic               flag_ff;
   logic signed [16:0] ox_ff, oy_ff;
   logic signed [15:0] decl_ff;
   logic               out_valid_ff, out_free, out_load;
   logic [15:0]        out_head_ff;
   logic               out_flag_ff;
   logic signed [16:0] out_ox_ff, out_oy_ff;

   assign out_free = !out_valid_ff || rsp.ready;
   assign q_pop = (st_ff == S_IDLE) && q_valid && (q_data.is_sample || out_free);
   assign out_load = (q_pop && !q_data.is_sample) || ((st_ff == S_WAIT) && out_free);
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign rnd = prod_ff + 48'sh0000_8000_0000;
   assign ang = 19'(rnd >>> 32);
   assign h0 = ang + 19'(decl_ff);

   always_comb begin
      h = h0;
      if (h < 0) h = h + 19'sd36000;
      if (h < 0) h = h + 19'sd36000;
      if (h > 19'sd36000) h = h - 19'sd36000;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.heading_centideg = out_head_ff;
   assign rsp.calibrating_flag = out_flag_ff;
   assign rsp.offset_x_doubled = out_ox_ff;
   assign rsp.offset_y_doubled = out_oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         head_ff <= '0;
         decl_ff <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_we) decl_ff <= csr_wdata;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (q_pop) begin
                  flag_ff <= q_data.flag; ox_ff <= q_data.ox; oy_ff <= q_data.oy;
                  if (q_data.is_sample) begin
                     cnt_ff <= '0;
                     if (q_data.dx == 0 && q_data.dy == 0) begin
                        z_ff <= '0;
                        st_ff <= S_SCALE;
                     end else begin
                        if (q_data.dx < 0 && q_data.dy >= 0) begin
                           x_ff <= q_data.dy; y_ff <= -q_data.dx; z_ff <= 32'h4000_0000;
                        end else if (q_data.dx < 0) begin
                           x_ff <= -q_data.dy; y_ff <= q_data.dx; z_ff <= 32'hC000_0000;
                        end else begin
                           x_ff <= q_data.dx; y_ff <= q_data.dy; z_ff <= '0;
                        end
                        st_ff <= S_RUN;
                     end
                  end else begin
                     out_head_ff <= head_ff;
                     out_flag_ff <= q_data.flag;
                     out_ox_ff <= q_data.ox;
                     out_oy_ff <= q_data.oy;
                  end
               end
            end
            S_RUN: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys; y_ff <= y_ff - xs; z_ff <= z_ff + atan_bam(cnt_ff);
               end else begin
                  x_ff <= x_ff - ys; y_ff <= y_ff + xs; z_ff <= z_ff - atan_bam(cnt_ff);
               end
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) st_ff <= S_SCALE;
            end
            S_SCALE: begin
               prod_ff <= 48'(signed'(z_ff)) * 48'sd36000;
               st_ff <= S_FOLD;
            end
            S_FOLD: begin
               head_ff <= 16'(h);
               st_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (out_free) begin
                  out_head_ff <= head_ff;
                  out_flag_ff <= flag_ff;
                  out_ox_ff <= ox_ff;
                  out_oy_ff <= oy_ff;
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> src/compass_heading_hard_iron_cal.sv
// Top level of the compass heading block with hard-iron calibration.
// A sample transaction passes through the queue and the steps of the shared iterative
// CORDIC rotator (skipped for a zero vector), then scaling, folding and the response
// register, and waits while the back end is busy or the response is held. Start and end
// calibration transactions respond through the queue and the response register. A
// two-entry queue lets new transactions be taken while a sample is in work. The
// declination register applies to every sample folded after it is written.
module compass_heading_hard_iron_cal (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic signed [15:0] csr_wdata,
   cal_req_if.sink           req,
   cal_rsp_if.source         rsp
);
   import chic_pkg::*;

   entry_type push_data, pop_data;
   logic      push, full, pop, not_empty;

   chic_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_full(full), .q_push(push), .q_data(push_data)
   );

   chic_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .full(full), .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
   );

   chic_back u_back (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .q_valid(not_empty), .q_data(pop_data), .q_pop(pop), .rsp(rsp)
   );
endmodule

>>> bench/compass_heading_scoreboard.sv
// Checker: predicts each heading response from observed requests and compares it.
module compass_heading_scoreboard (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic signed [15:0] csr_wdata,
   cal_req_if                 req,
   cal_rsp_if                 rsp,
   output int                 failures,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import chic_pkg::*;

   typedef struct {
      logic [15:0]        heading;
      logic               flag;
      logic signed [16:0] ox;
      logic signed [16:0] oy;
   } heading_record_type;

   heading_record_type heading_queue[$];

   longint x_sum, y_sum;
   int     x_lo, x_hi, y_lo, y_hi;
   logic   tracking;
   logic [15:0] heading_now;
   int     declination;

   function automatic longint angle_centideg(longint vx, longint vy);
      longint x, y, t, xs, ys, zs;
      logic [31:0] z;
      z = 32'h0;
      x = vx;
      y = vy;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 32'h40000000;
         end else begin
            t = x; x = -y; y = t; z = 32'hC0000000;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 25; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += atan_bam(CNT_W'(i));
         end else begin
            x -= ys; y += xs; z -= atan_bam(CNT_W'(i));
         end
      end
      zs = longint'($signed(z));
      return (zs * 36000 + 64'sd2147483648) >>> 32;
   endfunction

   function automatic heading_record_type predict_heading(logic [1:0] cmd,
                                                         logic signed [15:0] mx,
                                                         logic signed [15:0] my);
      heading_record_type r;
      longint h;
      int sx, sy;
      sx = int'(mx);
      sy = int'(my);
      if (cmd == CMD_SAMPLE) begin
         if (tracking) begin
            if (sx < x_lo) x_lo = sx;
            if (sx > x_hi) x_hi = sx;
            if (sy < y_lo) y_lo = sy;
            if (sy > y_hi) y_hi = sy;
         end
         h = angle_centideg((2 * longint'(sx) - x_sum) * 4096,
                            (2 * longint'(sy) - y_sum) * 4096) + declination;
         while (h < 0) h += FULL_CENTIDEG;
         while (h > FULL_CENTIDEG) h -= FULL_CENTIDEG;
         heading_now = 16'(h);
      end else if (cmd == CMD_START) begin
         tracking = 1'b1;
         x_lo = 32767; x_hi = -32768; y_lo = 32767; y_hi = -32768;
      end else if (cmd == CMD_END) begin
         tracking = 1'b0;
         x_sum = longint'(x_lo) + x_hi;
         y_sum = longint'(y_lo) + y_hi;
      end
      r.heading = heading_now;
      r.flag = tracking;
      r.ox = 17'(x_sum);
      r.oy = 17'(y_sum);
      return r;
   endfunction

   assign pending = heading_queue.size();

   always @(posedge clock) begin
      heading_record_type want;
      if (reset) begin
         x_sum = 0; y_sum = 0;
         x_lo = 32767; x_hi = -32768; y_lo = 32767; y_hi = -32768;
         tracking = 1'b0;
         heading_now = 16'd0;
         declination = 0;
         heading_queue.delete();
         failures <= 0;
      end else begin
         if (csr_we) declination = int'(csr_wdata);
         if (req.valid && req.ready)
            heading_queue.push_back(predict_heading(req.cmd, req.mag_x, req.mag_y));
         if (rsp.valid && rsp.ready) begin
            if (heading_queue.size() == 0) begin
               $display("%0t: unexpected response heading %0d flag %0d ox %0d oy %0d", $time,
                        rsp.heading_centideg, rsp.calibrating_flag, rsp.offset_x_doubled,
                        rsp.offset_y_doubled);
               failures <= failures + 1;
            end else begin
               want = heading_queue.pop_front();
               if (rsp.heading_centideg !== want.heading || rsp.calibrating_flag !== want.flag ||
                   rsp.offset_x_doubled !== want.ox || rsp.offset_y_doubled !== want.oy) begin
                  $display("%0t: mismatch expected heading %0d flag %0d ox %0d oy %0d",
                           $time, want.heading, want.flag, want.ox, want.oy);
                  $display("%0t:          actual heading %0d flag %0d ox %0d oy %0d",
                           $time, rsp.heading_centideg, rsp.calibrating_flag,
                           rsp.offset_x_doubled, rsp.offset_y_doubled);
                  failures <= failures + 1;
               end
            end
         end
      end
   end
endmodule

>>> bench/compass_heading_hard_iron_cal_tb.sv
// Testbench top: clock, reset, request and register stimulus, and the verdict.
module compass_heading_hard_iron_cal_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import chic_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int LATENCY_CYCLES = CORDIC_STEPS + 20;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   logic csr_we;
   logic signed [15:0] csr_wdata;
   int failures, pending, idle_mode;
   int cycle_count = 0;

   cal_req_if req_ch ();
   cal_rsp_if rsp_ch ();

   compass_heading_hard_iron_cal uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req_ch), .rsp(rsp_ch)
   );

   compass_heading_scoreboard scoreboard (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req_ch), .rsp(rsp_ch), .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("compass_heading_hard_iron_cal verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (idle_mode == 2) rsp_ch.ready <= ($urandom_range(99) >= 73);
      else if (idle_mode == 3) rsp_ch.ready <= ($urandom_range(99) >= 7);
      else rsp_ch.ready <= 1'b1;
   end

   task automatic send_item(logic [1:0] cmd, logic signed [15:0] mx, logic signed [15:0] my);
      int gap;
      gap = 0;
      if (idle_mode == 1) while ($urandom_range(99) < 73) gap++;
      else if (idle_mode == 3) while ($urandom_range(99) < 7) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.mag_x <= mx;
      req_ch.mag_y <= my;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_declination(logic signed [15:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample();
      send_item(CMD_SAMPLE, 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int items, run;
      logic signed [15:0] decl_choices[6];
      decl_choices = '{-16'sd18000, 16'sd18000, 16'sd0, -16'sd32768, 16'sd32767, 16'sd9000};
      idle_mode = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= 16'sd0;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_SAMPLE;
      req_ch.mag_x <= 16'sd0;
      req_ch.mag_y <= 16'sd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(CMD_SAMPLE, 16'sd0, 16'sd0);
      send_item(CMD_SAMPLE, -16'sd32768, -16'sd32768);
      send_item(CMD_SAMPLE, 16'sd32767, 16'sd32767);
      send_item(CMD_SAMPLE, -16'sd32768, 16'sd32767);
      send_item(CMD_SAMPLE, 16'sd32767, -16'sd32768);
      send_item(CMD_SAMPLE, -16'sd100, 16'sd0);
      send_item(CMD_SAMPLE, 16'sd0, -16'sd100);
      send_item(CMD_END, 16'sd0, 16'sd0);
      send_item(CMD_START, 16'sd5, 16'sd5);
      send_item(CMD_END, 16'sd0, 16'sd0);
      send_item(CMD_UNUSED, 16'sd7, 16'sd7);
      send_item(CMD_START, 16'sd0, 16'sd0);
      send_item(CMD_SAMPLE, 16'sd1000, -16'sd2000);
      send_item(CMD_SAMPLE, -16'sd3000, 16'sd4000);
      send_item(CMD_END, 16'sd0, 16'sd0);
      send_item(CMD_SAMPLE, 16'sd0, 16'sd1000);
      for (int i = 0; i < 6; i++) begin
         write_declination(decl_choices[i]);
         send_item(CMD_SAMPLE, 16'sd0, 16'sd0);
         send_item(CMD_SAMPLE, 16'sd1000, 16'sd1000);
      end

      items = 0;
      for (int phase = 0; items < 1450; phase++) begin
         idle_mode = phase % 4;
         if ($urandom_range(1)) write_declination(decl_choices[$urandom_range(5)]);
         else write_declination(16'($signed($urandom_range(36000)) - 18000));
         for (int k = 0; k < 180 && items < 1450; k++) begin
            if (phase == 2 && k == 90) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            if ($urandom_range(99) < 8) begin
               send_item(CMD_START, 16'($urandom), 16'($urandom));
               run = $urandom_range(25);
               for (int s = 0; s < run; s++) send_sample();
               if ($urandom_range(9) != 0) send_item(CMD_END, 16'($urandom), 16'($urandom));
               items += run + 2;
            end else if ($urandom_range(99) < 3) begin
               send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
               items++;
            end else begin
               send_sample();
               items++;
            end
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (failures == 0) $display("compass_heading_hard_iron_cal verification clean");
      else $display("compass_heading_hard_iron_cal verification failed");
      $finish;
   end
endmodule
